// ----- design/bf3_pkg.sv -----
package bf3_pkg;

  // Frame geometry
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int PIX_W             = 8;
  localparam int FW_W              = 11;
  localparam int FH_W              = 16;
  localparam int CFG_DATA_W        = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd4;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd4;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Neighborhood sum is at most 9 * 255 = 2295
  localparam int SUM_W = 12;

  // floor(s / 10) == (s * 6554) >> 16 for every s up to 2295
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_10   = 13'd6554;
  localparam int                RECIP_SHIFT = 16;

  // Result queue
  localparam int FIFO_DEPTH = 16;

  typedef struct packed {
    logic emit_a;   // result centered one column left of the item
    logic emit_b;   // extra row-end result centered on the last column
    logic last;     // emit_b is the final result of the frame
  } emit_t;

endpackage

// ----- design/box_filter_3x3_zero_pad_unit.sv -----
// 3x3 box filter with zero padding, one pixel per clock while s_tready is high.
//
// Channels: pixels enter on the s_* stream in raster order, s_tdata the gray
// value and s_tuser the kind (pixel or flush tick). After the H image rows the
// source sends W flush items that stand for the zero row below the frame.
// Results leave on the m_* stream: m_tdata = floor(3x3 sum / 10), m_tlast high
// on the final result of the frame. Width and height are written on the cfg_*
// channel (index 0 = frame_width, index 1 = frame_height) while the block is
// idle; any write restarts the frame position.
//
// Throughput: one item per clock while s_tready is high. Both line stores share one
// 16-bit wide single-read memory indexed by column, read at accept and written
// back in the following cycle, so neighboring items never touch the same entry.
// Pipeline: an item passes the stage 1, window and stage 3 registers before its
// result is queued; with the queue empty it can be taken on m_* in the next cycle.
// Results trail one row and one column; a row-end item past row 0 yields two.
// Stall: a 16-entry result queue decouples the sides; s_tready drops only when
// the queue plus results still in flight could overrun it.
// Reset: rst clears counters, window, pipeline and queue; width and height
// return to 4. The line store needs no clearing, rows above the frame read 0.
module box_filter_3x3_zero_pad_unit #(
  parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bf3_pkg::PIX_W-1:0]     s_tdata,   // [7:0] gray_pixel
  input  logic                          s_tuser,   // [0] kind
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bf3_pkg::PIX_W-1:0]     m_tdata,   // [7:0] filtered_pixel
  output logic                          m_tlast,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bf3_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WX    = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  logic cfg_wr;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  logic [WX-1:0]   fw_ext;
  logic [WX-1:0]   w_eff;
  logic [CW-1:0]   w_last;
  logic [FH_W-1:0] h_eff;

  // Clamp width to 2..MAX_WIDTH and height to at least 2
  always_comb begin
    fw_ext = WX'(frame_width);
    if (fw_ext < WX'(2)) begin
      w_eff = WX'(2);
    end else if (fw_ext > WX'(MAX_WIDTH)) begin
      w_eff = WX'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_last = CW'(w_eff - WX'(1));
    h_eff  = (frame_height < FH_W'(2)) ? FH_W'(2) : frame_height;
  end

  // ---------------------------------------------------------------------------
  // Accept stage: frame position and line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   column_count;
  logic [FH_W-1:0] row_count;

  logic            s_accept;
  logic [CW-1:0]   col;
  logic [FH_W-1:0] row;
  logic            padding_row;
  logic [PIX_W-1:0] pix_in;
  emit_t           emit_in;

  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    col         = (column_count > w_last) ? w_last : column_count;
    row         = (row_count > h_eff) ? h_eff : row_count;
    padding_row = (row >= h_eff);
    pix_in      = (s_tuser == KIND_FLUSH || padding_row) ? '0 : s_tdata;
    emit_in.emit_a = (row != '0) && (col != '0);
    emit_in.emit_b = (row != '0) && (col == w_last);
    emit_in.last   = padding_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      // Any register write restarts the frame
      column_count <= '0;
      row_count    <= '0;
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end else if (s_accept) begin
      if (col == w_last) begin
        column_count <= '0;
        row_count    <= padding_row ? '0 : row + FH_W'(1);
      end else begin
        column_count <= col + CW'(1);
        row_count    <= row;
      end
    end
  end

  // Line store: one word per column, upper row in [7:0], lower row in [15:8]
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rdata;

  // Stage 1 registers
  logic             s1_valid;
  logic [CW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_row_ge1;
  logic             s1_row_ge2;
  logic             s1_col0;
  emit_t            s1_emit;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      line_rdata <= line_mem[col];
    end
    // Write back: lower row moves up, new pixel becomes lower row
    if (s1_valid) begin
      line_mem[s1_addr] <= {s1_pix, line_rdata[2*PIX_W-1:PIX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= '0;
    end else begin
      s1_valid <= s_accept;
      s1_emit  <= s_accept ? emit_in : '0;
    end
    s1_addr    <= col;
    s1_pix     <= pix_in;
    s1_row_ge1 <= (row != '0);
    s1_row_ge2 <= (row > FH_W'(1));
    s1_col0    <= (col == '0);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window update (index row*3+col, col 2 newest, row 2 current)
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] up_pix;
  logic [PIX_W-1:0] lo_pix;

  assign up_pix = s1_row_ge2 ? line_rdata[PIX_W-1:0] : '0;
  assign lo_pix = s1_row_ge1 ? line_rdata[2*PIX_W-1:PIX_W] : '0;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3+0] <= s1_col0 ? '0 : win[r*3+1];
        win[r*3+1] <= s1_col0 ? '0 : win[r*3+2];
      end
      win[2] <= up_pix;
      win[5] <= lo_pix;
      win[8] <= s1_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: neighborhood sums
  // ---------------------------------------------------------------------------
  emit_t          s2_emit;
  emit_t          s3_emit;
  logic [SUM_W-1:0] sum_b;
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] s3_sum_a;
  logic [SUM_W-1:0] s3_sum_b;

  always_comb begin
    sum_b = SUM_W'(win[1]) + SUM_W'(win[2]) + SUM_W'(win[4]) +
            SUM_W'(win[5]) + SUM_W'(win[7]) + SUM_W'(win[8]);
    sum_a = sum_b + SUM_W'(win[0]) + SUM_W'(win[3]) + SUM_W'(win[6]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= '0;
      s3_emit <= '0;
    end else begin
      s2_emit <= s1_emit;
      s3_emit <= s2_emit;
    end
    s3_sum_a <= sum_a;
    s3_sum_b <= sum_b;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by ten through the reciprocal, push into the queue
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [PIX_W-1:0]  quot_a;
  logic [PIX_W-1:0]  quot_b;

  always_comb begin
    prod_a = PROD_W'(s3_sum_a) * PROD_W'(RECIP_10);
    prod_b = PROD_W'(s3_sum_b) * PROD_W'(RECIP_10);
    quot_a = prod_a[RECIP_SHIFT +: PIX_W];
    quot_b = prod_b[RECIP_SHIFT +: PIX_W];
  end

  // Result queue: entries hold {last, pixel}
  logic [PIX_W:0]   fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fifo_count;
  logic             pop;
  logic [1:0]       push_cnt;
  logic [PTR_W-1:0] wr_ptr_b;

  assign pop      = m_tvalid && m_tready;
  assign push_cnt = {1'b0, s3_emit.emit_a} + {1'b0, s3_emit.emit_b};
  assign wr_ptr_b = wr_ptr + PTR_W'(s3_emit.emit_a);

  always_ff @(posedge clk) begin
    if (s3_emit.emit_a) begin
      fifo_mem[wr_ptr] <= {1'b0, quot_a};
    end
    if (s3_emit.emit_b) begin
      fifo_mem[wr_ptr_b] <= {s3_emit.last, quot_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + PTR_W'(push_cnt);
      rd_ptr     <= rd_ptr + PTR_W'(pop);
      fifo_count <= fifo_count + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  assign m_tvalid = (fifo_count != '0);
  assign m_tdata  = fifo_mem[rd_ptr][PIX_W-1:0];
  assign m_tlast  = fifo_mem[rd_ptr][PIX_W];

  // Hold off input when queue plus in-flight results leave no room for two more
  logic [CNT_W:0] reserved;

  always_comb begin
    reserved = (CNT_W+1)'(fifo_count) +
               (CNT_W+1)'(s1_emit.emit_a) + (CNT_W+1)'(s1_emit.emit_b) +
               (CNT_W+1)'(s2_emit.emit_a) + (CNT_W+1)'(s2_emit.emit_b) +
               (CNT_W+1)'(s3_emit.emit_a) + (CNT_W+1)'(s3_emit.emit_b);
    s_tready = (reserved + (CNT_W+1)'(2)) <= (CNT_W+1)'(FIFO_DEPTH);
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overrun");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted item lost before write back");

  a_row_end_column: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit.emit_b) |-> (s1_addr == w_last))
    else $error("row-end result outside the last column");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (s3_emit.emit_a || s3_emit.emit_b) |=> m_tvalid)
    else $error("pushed result not presented");

endmodule
